### rtl/hamming_weight_ternary_sampler_core_assert.svh
// Assertion macros for the ternary sampler core.
`ifndef HAMMING_WEIGHT_TERNARY_SAMPLER_CORE_ASSERT_SVH
`define HAMMING_WEIGHT_TERNARY_SAMPLER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HWTS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("sampler check failed: same-cycle implication");
`define HWTS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("sampler check failed: next-cycle implication");
`else
`define HWTS_ASSERT_IMP(lbl, a, b)
`define HWTS_ASSERT_NXT(lbl, a, b)
`endif

`endif

### rtl/hwts_pkg.sv
package hwts_pkg;

  localparam int WEIGHT_W          = 7;
  localparam int SIGN_W            = 64;
  localparam int POS_W             = 12;
  localparam int COEF_W            = 2;
  localparam int LIST_AW           = 6;
  localparam int LOG_RING_SIZE_DEF = 12;

  localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = 7'd64;
  localparam logic [WEIGHT_W-1:0] CFG_RESET  = 7'd64;

  localparam logic OP_START = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  localparam logic signed [COEF_W-1:0] COEF_ZERO = 2'sb00;
  localparam logic signed [COEF_W-1:0] COEF_POS  = 2'sb01;
  localparam logic signed [COEF_W-1:0] COEF_NEG  = 2'sb11;

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  typedef struct packed {
    logic ready;
    logic occupied;
  } slot_stat_t;

endpackage

### rtl/hwts_slot_map.sv
module hwts_slot_map import hwts_pkg::*; #(
  parameter int ADDR_W = LOG_RING_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  output slot_stat_t        stat
);

  localparam int DEPTH = 1 << ADDR_W;

  logic              map_mem [DEPTH];
  logic              rd_data_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [ADDR_W-1:0] sweep_nxt;
  logic              ready_r;
  logic              ready_nxt;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;

  always_comb begin
    sweep_nxt = sweep_r;
    ready_nxt = ready_r;
    mem_we    = wr_en;
    mem_waddr = wr_addr;
    mem_wdata = wr_data;
    if (!ready_r) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_r;
      mem_wdata = 1'b0;
      sweep_nxt = sweep_r + 1'b1;
      if (sweep_r == {ADDR_W{1'b1}}) begin
        ready_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      ready_r <= 1'b0;
    end else begin
      sweep_r <= sweep_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= map_mem[rd_addr];
  end

  assign stat.ready    = ready_r;
  assign stat.occupied = rd_data_r;

endmodule

### rtl/hamming_weight_ternary_sampler_core.sv
// Fixed-weight sparse ternary sampler.
// Request channel: drive start with in_operation, in_sign_word and
// in_candidate_index; a request is taken on a clock edge with start high
// and busy low. A start request loads the sign word and clears the slot
// map; a candidate request tries to place one nonzero coefficient.
// Every request gives exactly one result, shown for one cycle with
// out_strobe high. The receiver cannot stall; results must be taken.
// A start result appears in the cycle after the request; busy then stays
// high in ST_CLEAR while the positions placed in the last sample are
// cleared from the slot map through the position list.
// For a candidate, the slot map is read in the request cycle, then
// ST_CHECK decides, writes back and registers the result, which appears
// in the next cycle. No new request is taken while in ST_CHECK, since
// the slot map memory has a registered read.
// After reset the slot map is swept to zero, one entry per cycle, and
// busy stays high until the sweep is done; cfg_we/cfg_wdata write the
// target weight at any time, but only while idle by contract.
module hamming_weight_ternary_sampler_core import hwts_pkg::*; #(
  parameter int LOG_RING_SIZE = LOG_RING_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_operation,
  input  logic [SIGN_W-1:0]        in_sign_word,
  input  logic [POS_W-1:0]         in_candidate_index,
  input  logic                     cfg_we,
  input  logic [WEIGHT_W-1:0]      cfg_wdata,
  output logic                     out_strobe,
  output logic                     out_placed,
  output logic [POS_W-1:0]         out_position,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [WEIGHT_W-1:0]      out_placed_count,
  output logic                     out_complete
);

  localparam int AW    = LOG_RING_SIZE;
  localparam int PW    = (LOG_RING_SIZE < POS_W) ? LOG_RING_SIZE : POS_W;
  localparam int LDEPTH = 1 << LIST_AW;

  state_t              state_r, state_nxt;
  logic [WEIGHT_W-1:0] hw_r;
  logic [SIGN_W-1:0]   sign_bits_r, sign_bits_nxt;
  logic [WEIGHT_W-1:0] count_r, count_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [WEIGHT_W-1:0] clr_total_r, clr_total_nxt;
  logic [WEIGHT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic                clr_pend_r, clr_pend_nxt;

  logic [PW-1:0]       list_mem [LDEPTH];
  logic [PW-1:0]       list_rdata_r;
  logic                list_we;
  logic [LIST_AW-1:0]  list_raddr;

  logic                out_strobe_r, out_strobe_nxt;
  logic                out_placed_r, out_placed_nxt;
  logic [POS_W-1:0]    out_position_r, out_position_nxt;
  logic signed [COEF_W-1:0] out_coef_r, out_coef_nxt;
  logic [WEIGHT_W-1:0] out_count_r, out_count_nxt;
  logic                out_complete_r, out_complete_nxt;

  logic [WEIGHT_W-1:0] target;
  logic                accept;
  logic                place;
  logic [AW-1:0]       map_raddr;
  logic                map_we;
  logic [AW-1:0]       map_waddr;
  logic                map_wdata;
  slot_stat_t          map_stat;

  assign target = (hw_r > MAX_WEIGHT) ? MAX_WEIGHT : hw_r;
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign place  = (count_r < target) && !map_stat.occupied;
  assign map_raddr = AW'(in_candidate_index[PW-1:0]);

  always_comb begin
    state_nxt        = state_r;
    sign_bits_nxt    = sign_bits_r;
    count_nxt        = count_r;
    pos_nxt          = pos_r;
    clr_total_nxt    = clr_total_r;
    clr_idx_nxt      = clr_idx_r;
    clr_pend_nxt     = 1'b0;
    list_we          = 1'b0;
    list_raddr       = clr_idx_r[LIST_AW-1:0];
    map_we           = 1'b0;
    map_waddr        = AW'(pos_r);
    map_wdata        = 1'b0;
    out_strobe_nxt   = 1'b0;
    out_placed_nxt   = 1'b0;
    out_position_nxt = out_position_r;
    out_coef_nxt     = out_coef_r;
    out_count_nxt    = out_count_r;
    out_complete_nxt = out_complete_r;
    case (state_r)
      ST_INIT: begin
        if (map_stat.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_START) begin
            sign_bits_nxt    = in_sign_word;
            clr_total_nxt    = count_r;
            clr_idx_nxt      = '0;
            count_nxt        = '0;
            out_strobe_nxt   = 1'b1;
            out_position_nxt = '0;
            out_coef_nxt     = COEF_ZERO;
            out_count_nxt    = '0;
            out_complete_nxt = (target == '0);
            state_nxt        = ST_CLEAR;
          end else begin
            pos_nxt   = in_candidate_index[PW-1:0];
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        out_strobe_nxt   = 1'b1;
        out_position_nxt = POS_W'(pos_r);
        out_coef_nxt     = COEF_ZERO;
        if (place) begin
          map_we         = 1'b1;
          map_wdata      = 1'b1;
          list_we        = 1'b1;
          count_nxt      = count_r + 1'b1;
          out_placed_nxt = 1'b1;
          out_coef_nxt   = sign_bits_r[count_r[LIST_AW-1:0]] ? COEF_NEG : COEF_POS;
        end
        out_count_nxt    = count_nxt;
        out_complete_nxt = (count_nxt >= target);
        state_nxt        = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_idx_r < clr_total_r) begin
          clr_idx_nxt  = clr_idx_r + 1'b1;
          clr_pend_nxt = 1'b1;
        end
        if (clr_pend_r) begin
          map_we    = 1'b1;
          map_waddr = AW'(list_rdata_r);
          map_wdata = 1'b0;
        end
        if (clr_idx_r == clr_total_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      hw_r         <= CFG_RESET;
      sign_bits_r  <= '0;
      count_r      <= '0;
      clr_total_r  <= '0;
      clr_idx_r    <= '0;
      clr_pend_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        hw_r <= cfg_wdata;
      end
      sign_bits_r  <= sign_bits_nxt;
      count_r      <= count_nxt;
      clr_total_r  <= clr_total_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_pend_r   <= clr_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r          <= pos_nxt;
    out_placed_r   <= out_placed_nxt;
    out_position_r <= out_position_nxt;
    out_coef_r     <= out_coef_nxt;
    out_count_r    <= out_count_nxt;
    out_complete_r <= out_complete_nxt;
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[count_r[LIST_AW-1:0]] <= pos_r;
    end
    list_rdata_r <= list_mem[list_raddr];
  end

  hwts_slot_map #(
    .ADDR_W (AW)
  ) u_slot_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (map_raddr),
    .wr_en   (map_we),
    .wr_addr (map_waddr),
    .wr_data (map_wdata),
    .stat    (map_stat)
  );

  assign out_strobe       = out_strobe_r;
  assign out_placed       = out_placed_r;
  assign out_position     = out_position_r;
  assign out_coefficient  = out_coef_r;
  assign out_placed_count = out_count_r;
  assign out_complete     = out_complete_r;

`include "hamming_weight_ternary_sampler_core_assert.svh"

  `HWTS_ASSERT_NXT(a_start_result, accept && (in_operation == OP_START), out_strobe)
  `HWTS_ASSERT_NXT(a_cand_busy, accept && (in_operation == OP_CAND), busy && !out_strobe)
  `HWTS_ASSERT_IMP(a_placed_coef, out_strobe && out_placed, out_coefficient != COEF_ZERO)
  `HWTS_ASSERT_IMP(a_count_cap, out_strobe, out_placed_count <= MAX_WEIGHT)

endmodule
